>>> design/rtc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtc_pkg;

  // Fixed widths of the bus fields.
  localparam int DATA_WIDTH  = 32;
  localparam int CFG_WIDTH   = 11;
  localparam int EPOCH_WIDTH = 40;
  localparam int FUNC_WIDTH  = 2;
  localparam int ADDR_WIDTH  = 4;

  // Defaults for the top-level parameters.
  localparam int CHANNELS_DEF       = 4;
  localparam int COUNT_WIDTH_DEF    = 24;
  localparam int PRESCALE_WIDTH_DEF = 11;

  // Item function codes.
  localparam logic [FUNC_WIDTH-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_WIDTH-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_WIDTH-1:0] FUNC_READ  = 2'd2;

  // Register map.
  localparam logic [ADDR_WIDTH-1:0] ADDR_START     = 4'd0;
  localparam logic [ADDR_WIDTH-1:0] ADDR_STOP      = 4'd1;
  localparam logic [ADDR_WIDTH-1:0] ADDR_CLEAR     = 4'd2;
  localparam logic [ADDR_WIDTH-1:0] ADDR_OVF_EVT   = 4'd3;
  localparam logic [ADDR_WIDTH-1:0] ADDR_CMP_EVT0  = 4'd4;
  localparam logic [ADDR_WIDTH-1:0] ADDR_CMP_EVT3  = 4'd7;
  localparam logic [ADDR_WIDTH-1:0] ADDR_INTEN_SET = 4'd8;
  localparam logic [ADDR_WIDTH-1:0] ADDR_INTEN_CLR = 4'd9;
  localparam logic [ADDR_WIDTH-1:0] ADDR_CMP_VAL0  = 4'd10;
  localparam logic [ADDR_WIDTH-1:0] ADDR_CMP_VAL3  = 4'd13;
  localparam logic [ADDR_WIDTH-1:0] ADDR_COUNTER   = 4'd14;
  localparam logic [ADDR_WIDTH-1:0] ADDR_EPOCH     = 4'd15;

  typedef struct packed {
    logic [FUNC_WIDTH-1:0] func;
    logic [ADDR_WIDTH-1:0] reg_addr;
    logic [DATA_WIDTH-1:0] write_data;
  } rtc_item_t;

endpackage

`default_nettype wire

>>> design/rtc_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module rtc_in_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rtc_pkg::rtc_item_t in_item,
  input  wire logic              advance,
  output logic                   stage_valid,
  output rtc_pkg::rtc_item_t     stage_item
);
  import rtc_pkg::*;

  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_item;
    end
  end

endmodule

`default_nettype wire

>>> design/rtc_timer.sv
`timescale 1ns / 1ps
`default_nettype none

module rtc_timer #(
  parameter int COUNT_WIDTH    = rtc_pkg::COUNT_WIDTH_DEF,
  parameter int PRESCALE_WIDTH = rtc_pkg::PRESCALE_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       go,
  input  wire rtc_pkg::rtc_item_t         item,
  input  wire logic [PRESCALE_WIDTH-1:0]  divider,
  output logic                            advance,
  output logic [COUNT_WIDTH-1:0]          count_next,
  output logic [rtc_pkg::EPOCH_WIDTH-1:0] epoch_next,
  output logic                            overflow_next
);
  import rtc_pkg::*;

  logic                      running;
  logic                      running_next;
  logic [PRESCALE_WIDTH-1:0] prescale_count;
  logic [PRESCALE_WIDTH-1:0] prescale_next;
  logic [COUNT_WIDTH-1:0]    tick_counter;
  logic [EPOCH_WIDTH-1:0]    epoch;
  logic                      overflow_event;
  logic                      is_tick;
  logic                      is_write;
  logic                      set_bit;
  logic                      data_zero;
  logic                      do_clear;

  always_comb begin
    is_tick   = go && (item.func == FUNC_TICK) && running;
    is_write  = go && (item.func == FUNC_WRITE);
    set_bit   = item.write_data[0];
    data_zero = (item.write_data == '0);
    do_clear  = is_write && (item.reg_addr == ADDR_CLEAR) && set_bit;
    advance   = is_tick && !(prescale_count < divider);

    running_next  = running;
    prescale_next = prescale_count;
    count_next    = tick_counter;
    epoch_next    = epoch;
    overflow_next = overflow_event;

    if (is_write && (item.reg_addr == ADDR_START) && set_bit) begin
      running_next = 1'b1;
    end
    if (is_write && (item.reg_addr == ADDR_STOP) && set_bit) begin
      running_next = 1'b0;
    end
    if (is_tick) begin
      if (advance) begin
        prescale_next = '0;
        count_next    = tick_counter + COUNT_WIDTH'(1);
        if (count_next == '0) begin
          overflow_next = 1'b1;
          epoch_next    = epoch + EPOCH_WIDTH'(1);
        end
      end else begin
        prescale_next = prescale_count + PRESCALE_WIDTH'(1);
      end
    end
    if (do_clear) begin
      prescale_next = '0;
      count_next    = '0;
      epoch_next    = '0;
    end
    if (is_write && (item.reg_addr == ADDR_OVF_EVT) && data_zero) begin
      overflow_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running        <= 1'b0;
      prescale_count <= '0;
      tick_counter   <= '0;
      epoch          <= '0;
      overflow_event <= 1'b0;
    end else begin
      running        <= running_next;
      prescale_count <= prescale_next;
      tick_counter   <= count_next;
      epoch          <= epoch_next;
      overflow_event <= overflow_next;
    end
  end

`ifndef NO_ASSERTIONS
  // A wrap of the counter raises the overflow event and bumps the epoch by one.
  a_wrap_bumps_epoch: assert property (@(posedge clk) disable iff (rst)
    (advance && (count_next == '0)) |=>
      (overflow_event && (tick_counter == '0) &&
       (epoch == EPOCH_WIDTH'($past(epoch) + EPOCH_WIDTH'(1)))))
    else $error("counter wrap did not raise overflow and bump epoch");

  // A tick while stopped leaves the counter and prescaler alone.
  a_stopped_tick: assert property (@(posedge clk) disable iff (rst)
    (go && (item.func == FUNC_TICK) && !running) |=>
      ($stable(tick_counter) && $stable(prescale_count)))
    else $error("tick changed the counter while stopped");
`endif

endmodule

`default_nettype wire

>>> design/rtc_cmp.sv
`timescale 1ns / 1ps
`default_nettype none

module rtc_cmp #(
  parameter int CHANNELS    = rtc_pkg::CHANNELS_DEF,
  parameter int COUNT_WIDTH = rtc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      go,
  input  wire rtc_pkg::rtc_item_t        item,
  input  wire logic                      advance,
  input  wire logic [COUNT_WIDTH-1:0]    count_next,
  output logic [CHANNELS-1:0]            events_next,
  output logic [rtc_pkg::DATA_WIDTH-1:0] rd_data
);
  import rtc_pkg::*;

  localparam int IDX_WIDTH = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [COUNT_WIDTH-1:0] compare_values [CHANNELS];
  logic [CHANNELS-1:0]    compare_events;
  logic                   is_write;
  logic [1:0]             evt_ch;
  logic [1:0]             val_ch;
  logic                   evt_ok;
  logic                   val_ok;

  assign is_write = go && (item.func == FUNC_WRITE);

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    logic wr_val;
    logic clr_evt;

    assign wr_val  = is_write && (item.reg_addr == ADDR_WIDTH'(ADDR_CMP_VAL0 + c));
    assign clr_evt = is_write && (item.reg_addr == ADDR_WIDTH'(ADDR_CMP_EVT0 + c)) &&
                     (item.write_data == '0);

    // An event is raised only when the counter steps onto the compare value.
    assign events_next[c] = (compare_events[c] && !clr_evt) ||
                            (advance && (count_next == compare_values[c]));

    always_ff @(posedge clk) begin
      if (rst) begin
        compare_values[c] <= '0;
      end else if (wr_val) begin
        compare_values[c] <= COUNT_WIDTH'(item.write_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_events <= '0;
    end else begin
      compare_events <= events_next;
    end
  end

  always_comb begin
    evt_ch  = 2'(item.reg_addr - ADDR_CMP_EVT0);
    val_ch  = 2'(item.reg_addr - ADDR_CMP_VAL0);
    evt_ok  = (3'(evt_ch) < 3'(CHANNELS));
    val_ok  = (3'(val_ch) < 3'(CHANNELS));
    rd_data = '0;
    if (item.reg_addr inside {[ADDR_CMP_EVT0:ADDR_CMP_EVT3]}) begin
      if (evt_ok) begin
        rd_data = DATA_WIDTH'(events_next[evt_ch[IDX_WIDTH-1:0]]);
      end
    end else if (item.reg_addr inside {[ADDR_CMP_VAL0:ADDR_CMP_VAL3]}) begin
      if (val_ok) begin
        rd_data = DATA_WIDTH'(compare_values[val_ch[IDX_WIDTH-1:0]]);
      end
    end
  end

`ifndef NO_ASSERTIONS
  // Register writes never raise a compare event.
  a_write_no_raise: assert property (@(posedge clk) disable iff (rst)
    (go && (item.func == FUNC_WRITE)) |=>
      ((compare_events & ~$past(compare_events)) == '0))
    else $error("register write raised a compare event");
`endif

endmodule

`default_nettype wire

>>> design/prescaled_rtc_with_compare.sv
// An accepted input beat sits in the input register, then one pass fills the
// result register, which offers the result beat until out_ready takes it.
// Throughput: one item per cycle while out_ready does not stall the result register;
// ticks and register accesses take the same single pass. The rate is set by the
// counter increment and the per-channel equality compares.
// Reset (rst, synchronous, active high) stops and clears the counter and clears the
// divider, compare values, events and interrupt enables; result data is not reset.
`timescale 1ns / 1ps
`default_nettype none

module prescaled_rtc_with_compare #(
  parameter int CHANNELS       = rtc_pkg::CHANNELS_DEF,
  parameter int COUNT_WIDTH    = rtc_pkg::COUNT_WIDTH_DEF,
  parameter int PRESCALE_WIDTH = rtc_pkg::PRESCALE_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Configuration write channel: the prescale divider minus one.
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rtc_pkg::CFG_WIDTH-1:0]    cfg_data,
  // Input channel.
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [rtc_pkg::FUNC_WIDTH-1:0]   func,
  input  wire logic [rtc_pkg::ADDR_WIDTH-1:0]   reg_addr,
  input  wire logic [rtc_pkg::DATA_WIDTH-1:0]   write_data,
  // Result channel.
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [rtc_pkg::DATA_WIDTH-1:0]        read_data,
  output logic                                  irq_line,
  output logic [CHANNELS-1:0]                   compare_pending,
  output logic                                  overflow_pending,
  output logic [rtc_pkg::EPOCH_WIDTH-1:0]       extended_count_high,
  output logic [COUNT_WIDTH-1:0]                count_now
);
  import rtc_pkg::*;

  rtc_item_t                 in_item;
  rtc_item_t                 stage_item;
  logic                      stage_valid;
  logic                      take;
  logic                      go;
  logic [PRESCALE_WIDTH-1:0] divider;
  logic                      advance;
  logic [COUNT_WIDTH-1:0]    count_next;
  logic [EPOCH_WIDTH-1:0]    epoch_next;
  logic                      overflow_next;
  logic [CHANNELS-1:0]       events_next;
  logic [DATA_WIDTH-1:0]     cmp_rd_data;
  logic [CHANNELS:0]         interrupt_enables;
  logic [CHANNELS:0]         enables_next;
  logic [DATA_WIDTH-1:0]     read_next;
  logic                      irq_next;
  logic                      is_write;

  // The divider register takes a write beat in any cycle. Only the low
  // PRESCALE_WIDTH bits are kept (or the value is zero-extended).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      divider <= '0;
    end else if (cfg_valid) begin
      divider <= PRESCALE_WIDTH'(cfg_data);
    end
  end

  assign in_item = '{func: func, reg_addr: reg_addr, write_data: write_data};

  // The staged item moves on whenever the result register is empty or its
  // beat is being taken, so a waiting result never holds up the input side
  // for more than the one staged item.
  assign take = !out_valid || out_ready;
  assign go   = stage_valid && take;

  rtc_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .advance     (take),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  rtc_timer #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .PRESCALE_WIDTH (PRESCALE_WIDTH)
  ) u_timer (
    .clk           (clk),
    .rst           (rst),
    .go            (go),
    .item          (stage_item),
    .divider       (divider),
    .advance       (advance),
    .count_next    (count_next),
    .epoch_next    (epoch_next),
    .overflow_next (overflow_next)
  );

  rtc_cmp #(
    .CHANNELS    (CHANNELS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_cmp (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .item        (stage_item),
    .advance     (advance),
    .count_next  (count_next),
    .events_next (events_next),
    .rd_data     (cmp_rd_data)
  );

  // Interrupt enables: bit 0 is the overflow event, bit c+1 is compare
  // channel c. Bits for absent channels are simply not stored.
  always_comb begin
    is_write     = go && (stage_item.func == FUNC_WRITE);
    enables_next = interrupt_enables;
    if (is_write && (stage_item.reg_addr == ADDR_INTEN_SET)) begin
      enables_next = interrupt_enables | stage_item.write_data[CHANNELS:0];
    end else if (is_write && (stage_item.reg_addr == ADDR_INTEN_CLR)) begin
      enables_next = interrupt_enables & ~stage_item.write_data[CHANNELS:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interrupt_enables <= '0;
    end else begin
      interrupt_enables <= enables_next;
    end
  end

  // Read data reflects the state after the item is applied. Reads never
  // change state, so the next values equal the current ones on a read.
  // Task addresses and unused function codes read as zero.
  always_comb begin
    read_next = '0;
    if (stage_item.func == FUNC_READ) begin
      case (stage_item.reg_addr)
        ADDR_OVF_EVT:   read_next = DATA_WIDTH'(overflow_next);
        ADDR_INTEN_SET,
        ADDR_INTEN_CLR: read_next = DATA_WIDTH'(enables_next);
        ADDR_COUNTER:   read_next = DATA_WIDTH'(count_next);
        ADDR_EPOCH:     read_next = epoch_next[DATA_WIDTH-1:0];
        default:        read_next = cmp_rd_data;
      endcase
    end
  end

  assign irq_next = |({events_next, overflow_next} & enables_next);

  // Result register: holds one finished beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      read_data           <= read_next;
      irq_line            <= irq_next;
      compare_pending     <= events_next;
      overflow_pending    <= overflow_next;
      extended_count_high <= epoch_next;
      count_now           <= count_next;
    end
  end

`ifndef NO_ASSERTIONS
  // The interrupt line is only raised with some event pending in the same beat.
  a_irq_has_source: assert property (@(posedge clk) disable iff (rst)
    (out_valid && irq_line) |-> (overflow_pending || (|compare_pending)))
    else $error("interrupt raised with no pending event");
`endif

endmodule

`default_nettype wire
